FILE: design/ssta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssta_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int FIELD_COORD    = 10;
    localparam int DEF_CAPACITY   = 32;
    localparam int DEF_COORD_BITS = 10;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_READ   = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_ACCUM    = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ_OK  = 3'd3,
        ST_READ_BAD = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef struct packed {
        logic cmp;
        logic acc;
        logic ins;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: design/sorted_sparse_triple_accumulator_top.sv
// Sorted sparse triple accumulator: a row of cells, one stored entry per cell.
// Each transaction passes a compare state (S_CMP), then an update state (S_UPD) that
// loads the output register. A new transaction is taken only in idle while the output
// register is free or being drained; the compare and update passes over the cell row
// are the limiting loop, one item in flight at a time.
// Reset (synchronous, active low) empties the store; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_sparse_triple_accumulator_top
    import ssta_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [9:0] key_row, [19:10] key_col, [51:20] add_value, [56:52] read_index
    input  wire logic [63:0] i_s_tdata,
    // [1:0] func
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [9:0] out_row, [19:10] out_col, [51:20] out_value, [57:52] entry_count
    output logic [63:0]      o_m_tdata,
    // [2:0] status
    output logic [2:0]       o_m_tuser
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;

    t_func                 r_func;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] r_col;
    logic [VALUE_BITS-1:0] r_val;
    logic [4:0]            r_idx;

    logic [CW-1:0] r_count, n_count;

    logic                   r_m_valid, n_m_valid;
    t_status                r_m_status, n_m_status;
    logic [FIELD_COORD-1:0] r_m_row, n_m_row;
    logic [FIELD_COORD-1:0] r_m_col, n_m_col;
    logic [VALUE_BITS-1:0]  r_m_val, n_m_val;
    logic [5:0]             r_m_count, n_m_count;

    logic [COORD_BITS-1:0] cell_row [CAPACITY];
    logic [COORD_BITS-1:0] cell_col [CAPACITY];
    logic [VALUE_BITS-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]   cell_gt;
    logic [CAPACITY-1:0]   cell_eq;
    logic [CAPACITY-1:0]   cell_occ;

    t_cell_ctl ctl;
    logic      s_accept;
    logic      found;
    logic      full;
    logic      rd_ok;

    logic [COORD_BITS+FIELD_COORD-1:0] in_row_ext;
    logic [COORD_BITS+FIELD_COORD-1:0] in_col_ext;
    logic [COORD_BITS+FIELD_COORD-1:0] rd_row_ext;
    logic [COORD_BITS+FIELD_COORD-1:0] rd_col_ext;
    logic [IW+CW+4:0]                  idx_ext;
    logic [IW+CW+4:0]                  cnt_ext;
    logic [CW+5:0]                     cnt_out_ext;

    assign o_s_tready = (r_state == S_IDLE) && (!r_m_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign in_row_ext = {{COORD_BITS{1'b0}}, i_s_tdata[9:0]};
    assign in_col_ext = {{COORD_BITS{1'b0}}, i_s_tdata[19:10]};

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_func <= t_func'(i_s_tuser);
            r_row  <= in_row_ext[COORD_BITS-1:0];
            r_col  <= in_col_ext[COORD_BITS-1:0];
            r_val  <= i_s_tdata[51:20];
            r_idx  <= i_s_tdata[56:52];
        end
    end

    assign found   = |cell_eq;
    assign full    = (r_count == CW'(CAPACITY));
    assign idx_ext = {{(IW + CW){1'b0}}, r_idx};
    assign cnt_ext = {{(IW + 5){1'b0}}, r_count};
    assign rd_ok   = (idx_ext < cnt_ext);

    always_comb begin
        ctl     = '0;
        ctl.cmp = (r_state == S_CMP);
        if ((r_state == S_UPD) && (r_func == FN_INSERT) && !full) begin
            ctl.acc = found;
            ctl.ins = !found;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [COORD_BITS-1:0] prev_row;
            logic [COORD_BITS-1:0] prev_col;
            logic [VALUE_BITS-1:0] prev_val;
            logic                  prev_gt;

            if (g == 0) begin : g_head
                assign prev_row = r_row;
                assign prev_col = r_col;
                assign prev_val = r_val;
                assign prev_gt  = 1'b0;
            end else begin : g_link
                assign prev_row = cell_row[g-1];
                assign prev_col = cell_col[g-1];
                assign prev_val = cell_val[g-1];
                assign prev_gt  = cell_gt[g-1];
            end

            assign cell_occ[g] = (CW'(g) < r_count);

            ssta_cell #(
                .COORD_BITS(COORD_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_occ      (cell_occ[g]),
                .i_new_row  (r_row),
                .i_new_col  (r_col),
                .i_new_val  (r_val),
                .i_prev_row (prev_row),
                .i_prev_col (prev_col),
                .i_prev_val (prev_val),
                .i_prev_gt  (prev_gt),
                .o_row      (cell_row[g]),
                .o_col      (cell_col[g]),
                .o_val      (cell_val[g]),
                .o_gt       (cell_gt[g]),
                .o_eq       (cell_eq[g])
            );
        end
    endgenerate

    assign rd_row_ext  = {{FIELD_COORD{1'b0}}, cell_row[idx_ext[IW-1:0]]};
    assign rd_col_ext  = {{FIELD_COORD{1'b0}}, cell_col[idx_ext[IW-1:0]]};
    assign cnt_out_ext = {6'b0, n_count};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_m_valid  = r_m_valid;
        n_m_status = r_m_status;
        n_m_row    = r_m_row;
        n_m_col    = r_m_col;
        n_m_val    = r_m_val;
        n_m_count  = r_m_count;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state    = S_IDLE;
                n_m_valid  = 1'b1;
                n_m_row    = '0;
                n_m_col    = '0;
                n_m_val    = '0;
                n_m_status = ST_READ_BAD;
                case (r_func)
                    FN_INSERT: begin
                        if (full) begin
                            n_m_status = ST_FULL;
                        end else if (found) begin
                            n_m_status = ST_ACCUM;
                        end else begin
                            n_m_status = ST_INSERTED;
                            n_count    = r_count + CW'(1);
                        end
                    end
                    FN_READ: begin
                        if (rd_ok) begin
                            n_m_status = ST_READ_OK;
                            n_m_row    = rd_row_ext[FIELD_COORD-1:0];
                            n_m_col    = rd_col_ext[FIELD_COORD-1:0];
                            n_m_val    = cell_val[idx_ext[IW-1:0]];
                        end
                    end
                    FN_CLEAR: begin
                        n_m_status = ST_CLEARED;
                        n_count    = '0;
                    end
                    default: begin
                        n_m_status = ST_READ_BAD;
                    end
                endcase
                n_m_count = cnt_out_ext[5:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_status <= n_m_status;
        r_m_row    <= n_m_row;
        r_m_col    <= n_m_col;
        r_m_val    <= n_m_val;
        r_m_count  <= n_m_count;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b0, r_m_count, r_m_val, r_m_col, r_m_row};
    assign o_m_tuser  = r_m_status;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(cell_eq))
        else $error("key matches more than one cell");

    a_upd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state == S_IDLE) && r_m_valid)
        else $error("update pass did not produce a result");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_status == ST_CLEARED)) |-> (r_count == '0))
        else $error("store not empty after clear");
`endif

endmodule

`default_nettype wire

FILE: design/ssta_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ssta_cell
    import ssta_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic                  i_occ,
    input  wire logic [COORD_BITS-1:0] i_new_row,
    input  wire logic [COORD_BITS-1:0] i_new_col,
    input  wire logic [VALUE_BITS-1:0] i_new_val,
    input  wire logic [COORD_BITS-1:0] i_prev_row,
    input  wire logic [COORD_BITS-1:0] i_prev_col,
    input  wire logic [VALUE_BITS-1:0] i_prev_val,
    input  wire logic                  i_prev_gt,
    output logic [COORD_BITS-1:0]      o_row,
    output logic [COORD_BITS-1:0]      o_col,
    output logic [VALUE_BITS-1:0]      o_val,
    output logic                       o_gt,
    output logic                       o_eq
);

    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                  r_gt, n_gt;
    logic                  r_eq, n_eq;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_val = r_val;
        n_gt  = r_gt;
        n_eq  = r_eq;
        if (i_ctl.cmp) begin
            n_gt = !i_occ || (r_row > i_new_row) ||
                   ((r_row == i_new_row) && (r_col > i_new_col));
            n_eq = i_occ && (r_row == i_new_row) && (r_col == i_new_col);
        end
        if (i_ctl.acc && r_eq) begin
            n_val = r_val + i_new_val;
        end
        if (i_ctl.ins && r_gt) begin
            if (i_prev_gt) begin
                n_row = i_prev_row;
                n_col = i_prev_col;
                n_val = i_prev_val;
            end else begin
                n_row = i_new_row;
                n_col = i_new_col;
                n_val = i_new_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gt <= 1'b0;
            r_eq <= 1'b0;
        end else begin
            r_gt <= n_gt;
            r_eq <= n_eq;
        end
    end

    assign o_row = r_row;
    assign o_col = r_col;
    assign o_val = r_val;
    assign o_gt  = r_gt;
    assign o_eq  = r_eq;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ssta_pkg::*;

    localparam logic [1:0] FN_UNUSED  = 2'd3;
    localparam int         NUM_ITEMS  = 1300;
    localparam int         QUIET_LO   = 500;
    localparam int         QUIET_HI   = 800;
    localparam int         DRAIN_WAIT = 10;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [31:0] val;
        logic [4:0]  idx;
    } t_op;

    typedef struct packed {
        t_status     status;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [31:0] val;
        logic [5:0]  count;
    } t_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [63:0] i_s_tdata  = '0;
    logic [1:0]  i_s_tuser  = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [63:0] o_m_tdata;
    logic [2:0]  o_m_tuser;

    sorted_sparse_triple_accumulator_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: sorted triples
    logic [9:0]  triple_rows [DEF_CAPACITY];
    logic [9:0]  triple_cols [DEF_CAPACITY];
    logic [31:0] triple_sums [DEF_CAPACITY];
    int          triple_count = 0;
    int          peak_count   = 0;

    t_op     pending_ops [$];
    t_result awaited_results [$];
    int      mismatches     = 0;
    int      results_seen   = 0;
    int      status_hits [8];
    int      ops_launched   = 0;
    int      results_taken  = 0;
    t_op     drive_op;

    function automatic t_result predict_triple_op(t_op op);
        t_result res;
        int      pos;
        bit      found;
        res = '0;
        case (op.func)
            FN_INSERT: begin
                if (triple_count >= DEF_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    pos   = 0;
                    found = 1'b0;
                    while (pos < triple_count) begin
                        if (triple_rows[pos] == op.row && triple_cols[pos] == op.col) begin
                            found = 1'b1;
                            break;
                        end
                        if (triple_rows[pos] > op.row ||
                            (triple_rows[pos] == op.row && triple_cols[pos] > op.col))
                            break;
                        pos++;
                    end
                    if (found) begin
                        triple_sums[pos] = triple_sums[pos] + op.val;
                        res.status = ST_ACCUM;
                    end else begin
                        for (int j = triple_count; j > pos; j--) begin
                            triple_rows[j] = triple_rows[j-1];
                            triple_cols[j] = triple_cols[j-1];
                            triple_sums[j] = triple_sums[j-1];
                        end
                        triple_rows[pos] = op.row;
                        triple_cols[pos] = op.col;
                        triple_sums[pos] = op.val;
                        triple_count++;
                        res.status = ST_INSERTED;
                    end
                end
            end
            FN_READ: begin
                if (op.idx < triple_count) begin
                    res.status = ST_READ_OK;
                    res.row    = triple_rows[op.idx];
                    res.col    = triple_cols[op.idx];
                    res.val    = triple_sums[op.idx];
                end else begin
                    res.status = ST_READ_BAD;
                end
            end
            FN_CLEAR: begin
                triple_count = 0;
                res.status   = ST_CLEARED;
            end
            default: res.status = ST_READ_BAD;
        endcase
        res.count = triple_count[5:0];
        if (triple_count > peak_count)
            peak_count = triple_count;
        return res;
    endfunction

    task automatic push_op(input logic [1:0] func, input logic [9:0] row,
                           input logic [9:0] col, input logic [31:0] val,
                           input logic [4:0] idx);
        t_op op;
        op.func = func;
        op.row  = row;
        op.col  = col;
        op.val  = val;
        op.idx  = idx;
        pending_ops.push_back(op);
    endtask

    task automatic push_random_op();
        int          pick;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [1:0]  func;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 60) begin
            row = 10'($urandom_range(0, 5));
            col = 10'($urandom_range(0, 7));
        end else begin
            row = 10'($urandom_range(0, 1023));
            col = 10'($urandom_range(0, 1023));
        end
        if (pick < 65)
            func = FN_INSERT;
        else if (pick < 92)
            func = FN_READ;
        else if (pick < 97)
            func = FN_UNUSED;
        else
            func = FN_CLEAR;
        push_op(func, row, col, $urandom, 5'($urandom_range(0, 31)));
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_ops.size() != 0 &&
                ((ops_launched >= QUIET_LO && ops_launched < QUIET_HI) ||
                 $urandom_range(0, 99) >= 10)) begin
                drive_op = pending_ops.pop_front();
                i_s_tvalid   <= 1'b1;
                i_s_tuser    <= drive_op.func;
                i_s_tdata    <= {7'd0, drive_op.idx, drive_op.val, drive_op.col, drive_op.row};
                ops_launched <= ops_launched + 1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result sink backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                results_taken <= results_taken + 1;
            i_m_tready <= (results_taken >= QUIET_LO && results_taken < QUIET_HI) ||
                          ($urandom_range(0, 99) >= 10);
        end
    end

    // scoreboard: check results first, then record the new transaction
    always @(posedge i_clk) begin
        t_result exp_res;
        t_op     acc_op;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result status=%0d data=%h",
                             $realtime, o_m_tuser, o_m_tdata);
            end else begin
                exp_res = awaited_results.pop_front();
                results_seen++;
                if (o_m_tuser !== exp_res.status || o_m_tdata[9:0] !== exp_res.row ||
                    o_m_tdata[19:10] !== exp_res.col || o_m_tdata[51:20] !== exp_res.val ||
                    o_m_tdata[57:52] !== exp_res.count || o_m_tdata[63:58] !== 6'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %0d mismatch: expected st=%0d row=%0d col=%0d ",
                                 $realtime, results_seen, exp_res.status, exp_res.row,
                                 exp_res.col,
                                 "val=%h cnt=%0d, got st=%0d row=%0d col=%0d val=%h cnt=%0d",
                                 exp_res.val, exp_res.count, o_m_tuser,
                                 o_m_tdata[9:0], o_m_tdata[19:10], o_m_tdata[51:20],
                                 o_m_tdata[57:52]);
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            acc_op.func = i_s_tuser;
            acc_op.row  = i_s_tdata[9:0];
            acc_op.col  = i_s_tdata[19:10];
            acc_op.val  = i_s_tdata[51:20];
            acc_op.idx  = i_s_tdata[56:52];
            exp_res = predict_triple_op(acc_op);
            status_hits[exp_res.status]++;
            awaited_results.push_back(exp_res);
        end
    end

    initial begin
        int n;
        foreach (status_hits[k])
            status_hits[k] = 0;

        // directed: empty store, extremes, wrap, zero sum, ordering, clear
        push_op(FN_READ,   10'd0,    10'd0,    32'h0000_0000, 5'd0);
        push_op(FN_UNUSED, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 5'd31);
        push_op(FN_INSERT, 10'd0,    10'd0,    32'h7FFF_FFFF, 5'd0);
        push_op(FN_INSERT, 10'd1023, 10'd1023, 32'h8000_0000, 5'd31);
        push_op(FN_INSERT, 10'd0,    10'd0,    32'h0000_0001, 5'd0);
        push_op(FN_INSERT, 10'd0,    10'd0,    32'h8000_0000, 5'd0);
        push_op(FN_INSERT, 10'd5,    10'd1023, 32'hFFFF_FFFF, 5'd21);
        push_op(FN_INSERT, 10'd5,    10'd0,    32'h1234_5678, 5'd10);
        push_op(FN_INSERT, 10'd0,    10'd1023, 32'h5555_5555, 5'd0);
        push_op(FN_INSERT, 10'd1023, 10'd0,    32'hAAAA_AAAA, 5'd0);
        push_op(FN_INSERT, 10'd5,    10'd1023, 32'h0000_0001, 5'd0);
        for (int k = 0; k <= 6; k++)
            push_op(FN_READ, 10'h2AA, 10'h155, 32'hDEAD_BEEF, k[4:0]);
        push_op(FN_READ,   10'd0,    10'd0,    32'd0, 5'd31);
        push_op(FN_CLEAR,  10'd1023, 10'd1023, 32'hFFFF_FFFF, 5'd31);
        push_op(FN_READ,   10'd0,    10'd0,    32'd0, 5'd0);
        push_op(FN_INSERT, 10'd512,  10'd512,  32'h0F0F_F0F0, 5'd0);
        push_op(FN_READ,   10'd0,    10'd0,    32'd0, 5'd0);

        // fill with descending keys so every insert shifts the whole store
        push_op(FN_CLEAR, 10'd0, 10'd0, 32'd0, 5'd0);
        for (int k = 0; k < DEF_CAPACITY; k++)
            push_op(FN_INSERT, 10'd900 - k[9:0], 10'd40 - k[9:0], $urandom, 5'd0);
        push_op(FN_INSERT, 10'd900, 10'd40, $urandom, 5'd0);
        push_op(FN_INSERT, 10'd0,   10'd0,  $urandom, 5'd0);
        push_op(FN_READ,   10'd0,   10'd0,  32'd0, 5'd31);
        push_op(FN_READ,   10'd0,   10'd0,  32'd0, 5'd0);

        // random episodes: mostly a clear followed by a burst of mixed traffic
        while (pending_ops.size() < NUM_ITEMS) begin
            if ($urandom_range(0, 99) < 80)
                push_op(FN_CLEAR, 10'($urandom), 10'($urandom), $urandom, 5'($urandom));
            n = $urandom_range(8, 60);
            for (int k = 0; k < n; k++)
                push_random_op();
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_s_tvalid)
            @(negedge i_clk);
        while (awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Checked %0d results: %0d new entries, %0d accumulations, %0d full drops,",
                 results_seen, status_hits[ST_INSERTED], status_hits[ST_ACCUM],
                 status_hits[ST_FULL]);
        $display("%0d good reads, %0d rejected reads/unused ops, %0d clears, peak fill %0d.",
                 status_hits[ST_READ_OK], status_hits[ST_READ_BAD],
                 status_hits[ST_CLEARED], peak_count);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", awaited_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
